// ----- design/plist_pkg.sv -----
package plist_pkg;

    localparam int POS_BITS          = 4;
    localparam int COUNT_BITS        = 5;
    localparam int ELEM_W            = 64;
    localparam int DEPTH_DEFAULT     = 16;
    localparam int ELEM_BITS_DEFAULT = 64;

    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_GET    = 2'd2,
        FUNC_FIND   = 2'd3
    } func_t;

    typedef struct packed {
        logic                shift_up;
        logic                shift_down;
        logic [POS_BITS-1:0] pos;
        logic [ELEM_W-1:0]   value;
    } cell_ctrl_t;

endpackage

// ----- design/plist_req_if.sv -----
interface plist_req_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    func;
    logic [plist_pkg::POS_BITS-1:0] position;
    logic [plist_pkg::ELEM_W-1:0]   element_value;

    modport source (output valid, output func, output position, output element_value,
                    input ready);
    modport sink (input valid, input func, input position, input element_value,
                  output ready);
endinterface

// ----- design/plist_rsp_if.sv -----
interface plist_rsp_if;
    logic                             valid;
    logic                             ready;
    logic                             success;
    logic [plist_pkg::ELEM_W-1:0]     element_out;
    logic [plist_pkg::POS_BITS-1:0]   found_position;
    logic [plist_pkg::COUNT_BITS-1:0] entry_count;
    logic                             is_empty;
    logic                             is_full;

    modport source (output valid, output success, output element_out,
                    output found_position, output entry_count, output is_empty,
                    output is_full, input ready);
    modport sink (input valid, input success, input element_out, input found_position,
                  input entry_count, input is_empty, input is_full, output ready);
endinterface

// ----- design/plist_cell.sv -----
module plist_cell #(
    parameter int DEPTH        = plist_pkg::DEPTH_DEFAULT,
    parameter int ELEMENT_BITS = plist_pkg::ELEM_BITS_DEFAULT,
    parameter int INDEX        = 0
) (
    input  logic                    clk,
    input  plist_pkg::cell_ctrl_t   ctrl,
    input  logic [ELEMENT_BITS-1:0] left_data,
    input  logic [ELEMENT_BITS-1:0] right_data,
    output logic [ELEMENT_BITS-1:0] data,
    output logic                    hit
);
    import plist_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMP_W = (IDX_W > POS_BITS) ? IDX_W : POS_BITS;

    logic [ELEMENT_BITS-1:0] data_reg;
    logic [ELEMENT_BITS-1:0] data_next;
    logic [CMP_W-1:0]        my_idx;
    logic [CMP_W-1:0]        pos_ext;

    assign my_idx  = CMP_W'(INDEX);
    assign pos_ext = CMP_W'(ctrl.pos);

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.shift_up)
        begin
            if (my_idx == pos_ext)
                data_next = ctrl.value[ELEMENT_BITS-1:0];
            else if (my_idx > pos_ext)
                data_next = left_data;
        end
        else if (ctrl.shift_down && (my_idx >= pos_ext))
        begin
            data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign hit  = (data_reg == ctrl.value[ELEMENT_BITS-1:0]);

endmodule

// ----- design/positional_list_insert_remove_find_unit.sv -----
// positional list unit: ordered list of up to DEPTH words in contiguous slots
// req channel (sink): func, position, element_value; one beat per operation
//   func insert, remove, get or find, see plist_pkg::func_t
// rsp channel (source): success, element_out, found_position, entry_count,
//   is_empty, is_full; exactly one beat per req beat, in order
// each slot is a cell of a shift chain; insert shifts the cells from the
// position up, remove shifts those above it down, all compare against the find word
// latency: the rsp beat is valid the cycle after the req beat is taken
// throughput: one op per cycle unless rsp stalls, set by the single result register
// a stalled rsp holds its beat and req.ready drops until the beat is taken;
// a new req beat is taken in the same cycle the held rsp beat leaves
// reset: list empty, no rsp beat pending; slot contents are not cleared
module positional_list_insert_remove_find_unit #(
    parameter int DEPTH        = plist_pkg::DEPTH_DEFAULT,
    parameter int ELEMENT_BITS = plist_pkg::ELEM_BITS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    plist_req_if.sink   req,
    plist_rsp_if.source rsp
);
    import plist_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > POS_BITS) ? CNT_W : POS_BITS;

    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     out_valid_reg;
    logic                     success_reg;
    logic                     success_next;
    logic [ELEM_W-1:0]        element_reg;
    logic [ELEM_W-1:0]        element_next;
    logic [POS_BITS-1:0]      found_reg;
    logic [POS_BITS-1:0]      found_next;

    logic                     accept;
    logic [CMP_W-1:0]         pos_ext;
    logic [CMP_W-1:0]         cnt_ext;
    logic                     insert_ok;
    logic                     in_range;
    cell_ctrl_t               ctrl;
    logic [ELEMENT_BITS-1:0]  cell_data [DEPTH];
    logic [DEPTH-1:0]         cell_hit;
    logic [DEPTH-1:0]         cell_valid;
    logic                     any_hit;
    logic [POS_BITS-1:0]      hit_idx;
    logic [ELEMENT_BITS-1:0]  get_data;

    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign pos_ext   = CMP_W'(req.position);
    assign cnt_ext   = CMP_W'(count_reg);
    assign insert_ok = (count_reg < CNT_W'(DEPTH)) && (pos_ext <= cnt_ext);
    assign in_range  = pos_ext < cnt_ext;

    always_comb
    begin
        ctrl.shift_up   = accept && (req.func == FUNC_INSERT) && insert_ok;
        ctrl.shift_down = accept && (req.func == FUNC_REMOVE) && in_range;
        ctrl.pos        = req.position;
        ctrl.value      = req.element_value;
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic [ELEMENT_BITS-1:0] left_d;
            logic [ELEMENT_BITS-1:0] right_d;
            if (g == 0)
            begin : g_first
                assign left_d = '0;
            end
            else
            begin : g_mid_l
                assign left_d = cell_data[g-1];
            end
            if (g == DEPTH - 1)
            begin : g_last
                assign right_d = '0;
            end
            else
            begin : g_mid_r
                assign right_d = cell_data[g+1];
            end
            plist_cell #(
                .DEPTH        (DEPTH),
                .ELEMENT_BITS (ELEMENT_BITS),
                .INDEX        (g)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .left_data  (left_d),
                .right_data (right_d),
                .data       (cell_data[g]),
                .hit        (cell_hit[g])
            );
            assign cell_valid[g] = CMP_W'(g) < cnt_ext;
        end
    endgenerate

    // first matching slot
    always_comb
    begin
        any_hit = 1'b0;
        hit_idx = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (cell_hit[i] && cell_valid[i])
            begin
                any_hit = 1'b1;
                hit_idx = POS_BITS'(i);
            end
        end
    end

    always_comb
    begin
        get_data = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (CMP_W'(i) == pos_ext)
                get_data = get_data | cell_data[i];
        end
    end

    always_comb
    begin
        count_next   = count_reg;
        success_next = 1'b0;
        element_next = '0;
        found_next   = '0;
        case (req.func)
            FUNC_INSERT:
            begin
                success_next = insert_ok;
                if (insert_ok)
                    count_next = count_reg + 1'b1;
            end
            FUNC_REMOVE:
            begin
                success_next = in_range;
                if (in_range)
                    count_next = count_reg - 1'b1;
            end
            FUNC_GET:
            begin
                success_next = in_range;
                if (in_range)
                    element_next = ELEM_W'(get_data);
            end
            FUNC_FIND:
            begin
                success_next = any_hit;
                found_next   = hit_idx;
            end
            default:
            begin
                success_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            success_reg <= success_next;
            element_reg <= element_next;
            found_reg   <= found_next;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.success        = success_reg;
    assign rsp.element_out    = element_reg;
    assign rsp.found_position = found_reg;
    assign rsp.entry_count    = COUNT_BITS'(count_reg);
    assign rsp.is_empty       = (count_reg == '0);
    assign rsp.is_full        = (count_reg == CNT_W'(DEPTH));

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("list count above depth");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.shift_up |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not grow the list");

    a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.shift_down |=> count_reg == $past(count_reg) - 1'b1)
        else $error("remove did not shrink the list");

    a_beat_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp.valid)
        else $error("no rsp beat after req beat");

    a_count_steady: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(count_reg))
        else $error("count changed without a req beat");

endmodule
